// ===== rtl/rnl_pkg.sv =====
// ----------------------------------------------------------------------------
// rnl_pkg
// Shared codes, command and status types of the NACK list manager.
// ----------------------------------------------------------------------------
package rnl_pkg;

  // operation codes of an input item
  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_SCAN   = 3'd2;
  localparam logic [2:0] FUNC_CHECK  = 3'd3;
  localparam logic [2:0] FUNC_RTT    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_NACK    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_FULL    = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_REQ    = 3'd0;
  localparam logic [2:0] CFG_MAX_ALIVE  = 3'd1;
  localparam logic [2:0] CFG_FIRST_WAIT = 3'd2;
  localparam logic [2:0] CFG_MIN_INT    = 3'd3;
  localparam logic [2:0] CFG_MAX_INT    = 3'd4;
  localparam logic [2:0] CFG_CHECK      = 3'd5;
  localparam logic [2:0] CFG_QLIMIT     = 3'd6;
  localparam logic [2:0] CFG_START_INT  = 3'd7;

  // configuration reset values
  localparam logic [7:0]  RST_MAX_REQ    = 8'd10;
  localparam logic [23:0] RST_MAX_ALIVE  = 24'd1000000;
  localparam logic [23:0] RST_FIRST_WAIT = 24'd10000;
  localparam logic [23:0] RST_MIN_INT    = 24'd15000;
  localparam logic [23:0] RST_MAX_INT    = 24'd500000;
  localparam logic [23:0] RST_CHECK      = 24'd15000;
  localparam logic [6:0]  RST_QLIMIT     = 7'd64;
  localparam logic [23:0] RST_START_INT  = 24'd50000;

  // arithmetic constants
  localparam int          MAX_RESULTS       = 64;
  localparam logic [23:0] SHORT_INTERVAL_US = 24'd50000;
  localparam logic [23:0] DIV3_RECIP        = 24'hAAAAAB;     // ceil(2^25 / 3)
  localparam logic [28:0] DIV5_RECIP        = 29'h1999999A;   // ceil(2^31 / 5)
  localparam logic [9:0]  RTT_SCALE         = 10'd1000;

  // per-cycle datapath commands
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INS_START,
    CMD_READ,
    CMD_INS_EVAL,
    CMD_NEXT_VAL,
    CMD_OVF,
    CMD_SH_START,
    CMD_SH_READ,
    CMD_SH_WRITE,
    CMD_INS_WRITE,
    CMD_IDX0,
    CMD_IDX_INC,
    CMD_DEL_START,
    CMD_COPY_WRITE,
    CMD_COPY_END,
    CMD_SCAN_START,
    CMD_SCAN_EVAL,
    CMD_CHK_SIZE,
    CMD_RTT0,
    CMD_RTT1,
    CMD_RTT2,
    CMD_RTT3,
    CMD_PUSH_DONE,
    CMD_OUT_READ,
    CMD_OUT_NEXT
  } dp_cmd_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic [2:0] func;
    logic       idx_eq_count;
    logic       cur_eq_end;
    logic       dup;
    logic       table_full;
    logic       shift_done;
    logic       match;
    logic       early;
    logic       res_full;
    logic       young;
    logic       last_res;
  } dp_status_t;

  // one table entry
  typedef struct packed {
    logic [15:0] seq;
    logic [47:0] born;
    logic [47:0] lreq;
    logic [7:0]  rcnt;
  } entry_t;

  // one buffered result
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [6:0]  tmo;
  } res_t;

endpackage

// ===== rtl/rnl_in_if.sv =====
// ----------------------------------------------------------------------------
// rnl_in_if
// Input channel: one operation per transfer.
// ----------------------------------------------------------------------------
interface rnl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] seq_first;
  logic [15:0] seq_end;
  logic [47:0] now_us;
  logic [15:0] rtt_ms;

  modport source (output valid, func, seq_first, seq_end, now_us, rtt_ms, input ready);
  modport sink   (input valid, func, seq_first, seq_end, now_us, rtt_ms, output ready);
endinterface

// ===== rtl/rnl_out_if.sv =====
// ----------------------------------------------------------------------------
// rnl_out_if
// Output channel: one result per transfer.
// ----------------------------------------------------------------------------
interface rnl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] seq_out;
  logic [6:0]  timeout_count;
  logic [6:0]  entry_count;
  logic        overflow;
  logic        last;

  modport source (output valid, kind, seq_out, timeout_count, entry_count, overflow, last,
                  input ready);
  modport sink   (input valid, kind, seq_out, timeout_count, entry_count, overflow, last,
                  output ready);
endinterface

// ===== rtl/rtp_nack_list_manager_top.sv =====
// ----------------------------------------------------------------------------
// rtp_nack_list_manager_top
// Sorted table of missing RTP sequence numbers with NACK scheduling.
//
//   channel  direction  transfer carries
//   in_if    sink       func, seq_first, seq_end, now_us, rtt_ms
//   out_if   source     kind, seq_out, timeout_count, entry_count, overflow, last
//   cfg      write      cfg_idx_i selects register, cfg_data_i value
//
// One operation at a time; in_if.ready is high only when idle.
// Insert: each value walks the table for a duplicate and its position, shifts the tail up and writes.
// Scan and remove walk the table entry by entry and compact it behind the walk.
// Results leave one at a time from a result buffer, held while out_if is not ready.
// Reset is immediate; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module rtp_nack_list_manager_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  rnl_in_if.sink      in_if,
  rnl_out_if.source   out_if
);
  import rnl_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t status;

  // sequencer
  rnl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // table and arithmetic
  rnl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (in_if.func),
    .seq_first_i     (in_if.seq_first),
    .seq_end_i       (in_if.seq_end),
    .now_us_i        (in_if.now_us),
    .rtt_ms_i        (in_if.rtt_ms),
    .kind_o          (out_if.kind),
    .seq_out_o       (out_if.seq_out),
    .timeout_count_o (out_if.timeout_count),
    .entry_count_o   (out_if.entry_count),
    .overflow_o      (out_if.overflow),
    .last_o          (out_if.last)
  );

endmodule

// ===== rtl/rnl_ctrl.sv =====
// ----------------------------------------------------------------------------
// rnl_ctrl
// Operation sequencer: walks the table and drains results through commands.
// ----------------------------------------------------------------------------
module rnl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rnl_pkg::dp_status_t status_i,
  output rnl_pkg::dp_cmd_e    cmd_o
);
  import rnl_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP,
    ST_I_START, ST_I_RD, ST_I_EV, ST_I_DEC, ST_I_SH, ST_I_SHW, ST_I_WR,
    ST_R_RD, ST_R_EV, ST_C_RD, ST_C_WR,
    ST_S_CHK, ST_S_RD, ST_S_EV,
    ST_Q, ST_U0, ST_U1, ST_U2, ST_U3,
    ST_FIN, ST_O_RD, ST_O_VAL
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_O_VAL);

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        priority if (status_i.func == FUNC_INSERT) begin
          state_d = ST_I_START;
        end else if (status_i.func == FUNC_REMOVE) begin
          cmd_o   = CMD_IDX0;
          state_d = ST_R_RD;
        end else if (status_i.func == FUNC_SCAN) begin
          state_d = ST_S_CHK;
        end else if (status_i.func == FUNC_CHECK) begin
          state_d = ST_Q;
        end else if (status_i.func == FUNC_RTT) begin
          state_d = ST_U0;
        end else begin
          state_d = ST_FIN;
        end
      end
      // insert: search for duplicate and position
      ST_I_START: begin
        cmd_o   = CMD_INS_START;
        state_d = status_i.cur_eq_end ? ST_FIN : ST_I_RD;
      end
      ST_I_RD: begin
        if (status_i.idx_eq_count) begin
          state_d = ST_I_DEC;
        end else begin
          cmd_o   = CMD_READ;
          state_d = ST_I_EV;
        end
      end
      ST_I_EV: begin
        if (status_i.dup) begin
          cmd_o   = CMD_NEXT_VAL;
          state_d = ST_I_START;
        end else begin
          cmd_o   = CMD_INS_EVAL;
          state_d = ST_I_RD;
        end
      end
      ST_I_DEC: begin
        if (status_i.table_full) begin
          cmd_o   = CMD_OVF;
          state_d = ST_FIN;
        end else begin
          cmd_o   = CMD_SH_START;
          state_d = ST_I_SH;
        end
      end
      // insert: shift the tail up one slot
      ST_I_SH: begin
        if (status_i.shift_done) begin
          state_d = ST_I_WR;
        end else begin
          cmd_o   = CMD_SH_READ;
          state_d = ST_I_SHW;
        end
      end
      ST_I_SHW: begin
        cmd_o   = CMD_SH_WRITE;
        state_d = ST_I_SH;
      end
      ST_I_WR: begin
        cmd_o   = CMD_INS_WRITE;
        state_d = ST_I_START;
      end
      // remove: find the entry
      ST_R_RD: begin
        if (status_i.idx_eq_count) begin
          state_d = ST_FIN;
        end else begin
          cmd_o   = CMD_READ;
          state_d = ST_R_EV;
        end
      end
      ST_R_EV: begin
        if (status_i.match) begin
          cmd_o   = CMD_DEL_START;
          state_d = ST_C_RD;
        end else begin
          cmd_o   = CMD_IDX_INC;
          state_d = ST_R_RD;
        end
      end
      // compaction: copy the tail down to the write pointer
      ST_C_RD: begin
        if (status_i.idx_eq_count) begin
          cmd_o   = CMD_COPY_END;
          state_d = ST_FIN;
        end else begin
          cmd_o   = CMD_READ;
          state_d = ST_C_WR;
        end
      end
      ST_C_WR: begin
        cmd_o   = CMD_COPY_WRITE;
        state_d = ST_C_RD;
      end
      // scan
      ST_S_CHK: begin
        if (status_i.early) begin
          state_d = ST_FIN;
        end else begin
          cmd_o   = CMD_SCAN_START;
          state_d = ST_S_RD;
        end
      end
      ST_S_RD: begin
        if (status_i.idx_eq_count || status_i.res_full) begin
          state_d = ST_C_RD;
        end else begin
          cmd_o   = CMD_READ;
          state_d = ST_S_EV;
        end
      end
      ST_S_EV: begin
        if (status_i.young) begin
          state_d = ST_C_RD;
        end else begin
          cmd_o   = CMD_SCAN_EVAL;
          state_d = ST_S_RD;
        end
      end
      ST_Q: begin
        cmd_o   = CMD_CHK_SIZE;
        state_d = ST_FIN;
      end
      // interval smoothing
      ST_U0: begin
        cmd_o   = CMD_RTT0;
        state_d = ST_U1;
      end
      ST_U1: begin
        cmd_o   = CMD_RTT1;
        state_d = ST_U2;
      end
      ST_U2: begin
        cmd_o   = CMD_RTT2;
        state_d = ST_U3;
      end
      ST_U3: begin
        cmd_o   = CMD_RTT3;
        state_d = ST_FIN;
      end
      // result drain
      ST_FIN: begin
        cmd_o   = CMD_PUSH_DONE;
        state_d = ST_O_RD;
      end
      ST_O_RD: begin
        cmd_o   = CMD_OUT_READ;
        state_d = ST_O_VAL;
      end
      ST_O_VAL: begin
        if (out_ready_i) begin
          cmd_o   = CMD_OUT_NEXT;
          state_d = status_i.last_res ? ST_IDLE : ST_O_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rnl_datapath.sv =====
// ----------------------------------------------------------------------------
// rnl_datapath
// Entry table, result buffer, configuration and timing arithmetic.
// ----------------------------------------------------------------------------
module rnl_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  input  rnl_pkg::dp_cmd_e    cmd_i,
  output rnl_pkg::dp_status_t status_o,
  input  logic [2:0]          func_i,
  input  logic [15:0]         seq_first_i,
  input  logic [15:0]         seq_end_i,
  input  logic [47:0]         now_us_i,
  input  logic [15:0]         rtt_ms_i,
  output logic [1:0]          kind_o,
  output logic [15:0]         seq_out_o,
  output logic [6:0]          timeout_count_o,
  output logic [6:0]          entry_count_o,
  output logic                overflow_o,
  output logic                last_o
);
  import rnl_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int LW  = (CW > 7) ? CW : 7;
  localparam int RAW = $clog2(MAX_RESULTS);

  function automatic logic seq_before(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return (d != 16'd0) && !d[15];
  endfunction

  // configuration
  logic [7:0]  max_req_q;
  logic [23:0] max_alive_q, first_wait_q, min_int_q, max_int_q, check_q;
  logic [6:0]  qlimit_q;

  // latched operation
  logic [2:0]  func_q;
  logic [15:0] sfirst_q, send_q, cur_q;
  logic [47:0] now_q;
  logic [15:0] rtt_q;

  // walk state
  logic [CW-1:0] count_q, idx_q, pos_q, wp_q, idx_m1;
  logic          pset_q, ovf_q;
  logic [6:0]    nres_q, drops_q, oj_q;
  logic [47:0]   last_scan_q;
  logic [23:0]   interval_q, ival_q;

  // interval smoothing pipeline
  logic [25:0] r_q, quot_q, v_sel;
  logic [27:0] num_q;
  logic        gt_q;

  // memories and read registers
  entry_t tb_mem [TABLE_DEPTH];
  entry_t ent_q;
  res_t   rb_mem [MAX_RESULTS];
  res_t   rb_q;

  logic          tb_ren, tb_we, rb_we;
  logic [AW-1:0] tb_raddr, tb_waddr;
  entry_t        tb_wdata, upd;
  res_t          rb_wdata;

  // timing compares
  logic signed [49:0] age, since_req, since_scan;
  logic               drop, young, due, early, list_full;
  logic [47:0]        prod3;
  logic [23:0]        base, ival_d;
  logic [56:0]        prod5;

  assign idx_m1     = idx_q - 1'b1;
  assign age        = $signed({2'b00, now_q}) - $signed({2'b00, ent_q.born});
  assign since_req  = $signed({2'b00, now_q}) - $signed({2'b00, ent_q.lreq});
  assign since_scan = $signed({2'b00, now_q}) - $signed({2'b00, last_scan_q});
  assign drop       = (age > $signed({26'd0, max_alive_q})) || (ent_q.rcnt > max_req_q);
  assign young      = age < $signed({26'd0, first_wait_q});
  assign due        = since_req >= $signed({26'd0, ival_q});
  assign early      = since_scan < $signed({26'd0, check_q});
  assign list_full  = LW'(count_q) >= LW'(qlimit_q);

  // retry interval: long intervals are cut to a third, never below the minimum interval
  assign prod3  = interval_q * DIV3_RECIP;
  assign base   = (interval_q < SHORT_INTERVAL_US) ? interval_q : {1'b0, prod3[47:25]};
  assign ival_d = (base > min_int_q) ? base : min_int_q;

  // divide by five through the reciprocal
  assign prod5 = 57'(num_q) * 57'(DIV5_RECIP);
  assign v_sel = gt_q ? quot_q : r_q;

  // entry after a request
  always_comb begin
    upd = ent_q;
    if (due) begin
      upd.lreq = now_q;
      upd.rcnt = (ent_q.rcnt == 8'hFF) ? ent_q.rcnt : ent_q.rcnt + 8'd1;
    end
  end

  // memory port selection
  always_comb begin
    tb_ren   = 1'b0;
    tb_raddr = idx_q[AW-1:0];
    tb_we    = 1'b0;
    tb_waddr = idx_q[AW-1:0];
    tb_wdata = ent_q;
    rb_we    = 1'b0;
    rb_wdata = '{kind: KIND_DONE, seq: 16'd0, tmo: drops_q};
    unique case (cmd_i)
      CMD_READ: tb_ren = 1'b1;
      CMD_SH_READ: begin
        tb_ren   = 1'b1;
        tb_raddr = idx_m1[AW-1:0];
      end
      CMD_SH_WRITE: tb_we = 1'b1;
      CMD_INS_WRITE: begin
        tb_we    = 1'b1;
        tb_waddr = pos_q[AW-1:0];
        tb_wdata = '{seq: cur_q, born: now_q, lreq: 48'd0, rcnt: 8'd0};
      end
      CMD_COPY_WRITE: begin
        tb_we    = 1'b1;
        tb_waddr = wp_q[AW-1:0];
      end
      CMD_SCAN_EVAL: begin
        tb_we    = !drop;
        tb_waddr = wp_q[AW-1:0];
        tb_wdata = upd;
        rb_we    = drop || due;
        rb_wdata = drop ? '{kind: KIND_TIMEOUT, seq: ent_q.seq, tmo: drops_q + 7'd1}
                        : '{kind: KIND_NACK, seq: ent_q.seq, tmo: drops_q};
      end
      CMD_CHK_SIZE: begin
        rb_we    = list_full;
        rb_wdata = '{kind: KIND_FULL, seq: 16'd0, tmo: 7'd0};
      end
      CMD_PUSH_DONE: rb_we = (nres_q == 7'd0);
      default: ;
    endcase
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      tb_mem[tb_waddr] <= tb_wdata;
    end
    if (tb_ren) begin
      ent_q <= tb_mem[tb_raddr];
    end
  end

  // result buffer
  always_ff @(posedge clk_i) begin
    if (rb_we) begin
      rb_mem[nres_q[RAW-1:0]] <= rb_wdata;
    end
    if (cmd_i == CMD_OUT_READ) begin
      rb_q <= rb_mem[oj_q[RAW-1:0]];
    end
  end

  // configuration registers; the start interval only matters at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q    <= RST_MAX_REQ;
      max_alive_q  <= RST_MAX_ALIVE;
      first_wait_q <= RST_FIRST_WAIT;
      min_int_q    <= RST_MIN_INT;
      max_int_q    <= RST_MAX_INT;
      check_q      <= RST_CHECK;
      qlimit_q     <= RST_QLIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_REQ:    max_req_q    <= cfg_data_i[7:0];
        CFG_MAX_ALIVE:  max_alive_q  <= cfg_data_i;
        CFG_FIRST_WAIT: first_wait_q <= cfg_data_i;
        CFG_MIN_INT:    min_int_q    <= cfg_data_i;
        CFG_MAX_INT:    max_int_q    <= cfg_data_i;
        CFG_CHECK:      check_q      <= cfg_data_i;
        CFG_QLIMIT:     qlimit_q     <= cfg_data_i[6:0];
        CFG_START_INT:  ;
        default:        ;
      endcase
    end
  end

  // operation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q      <= FUNC_INSERT;
      sfirst_q    <= '0;
      send_q      <= '0;
      cur_q       <= '0;
      now_q       <= '0;
      rtt_q       <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      wp_q        <= '0;
      pset_q      <= 1'b0;
      ovf_q       <= 1'b0;
      nres_q      <= '0;
      drops_q     <= '0;
      oj_q        <= '0;
      last_scan_q <= '0;
      interval_q  <= RST_START_INT;
      ival_q      <= '0;
      r_q         <= '0;
      num_q       <= '0;
      gt_q        <= 1'b0;
      quot_q      <= '0;
    end else begin
      unique case (cmd_i)
        CMD_LOAD: begin
          func_q   <= func_i;
          sfirst_q <= seq_first_i;
          send_q   <= seq_end_i;
          cur_q    <= seq_first_i;
          now_q    <= now_us_i;
          rtt_q    <= rtt_ms_i;
          nres_q   <= '0;
          drops_q  <= '0;
          ovf_q    <= 1'b0;
          oj_q     <= '0;
        end
        CMD_INS_START: begin
          idx_q  <= '0;
          pos_q  <= count_q;
          pset_q <= 1'b0;
        end
        CMD_INS_EVAL: begin
          if (!pset_q && seq_before(cur_q, ent_q.seq)) begin
            pos_q  <= idx_q;
            pset_q <= 1'b1;
          end
          idx_q <= idx_q + 1'b1;
        end
        CMD_NEXT_VAL: cur_q <= cur_q + 16'd1;
        CMD_OVF:      ovf_q <= 1'b1;
        CMD_SH_START: idx_q <= count_q;
        CMD_SH_WRITE: idx_q <= idx_m1;
        CMD_INS_WRITE: begin
          count_q <= count_q + 1'b1;
          cur_q   <= cur_q + 16'd1;
        end
        CMD_IDX0:    idx_q <= '0;
        CMD_IDX_INC: idx_q <= idx_q + 1'b1;
        CMD_DEL_START: begin
          wp_q  <= idx_q;
          idx_q <= idx_q + 1'b1;
        end
        CMD_COPY_WRITE: begin
          wp_q  <= wp_q + 1'b1;
          idx_q <= idx_q + 1'b1;
        end
        CMD_COPY_END: count_q <= wp_q;
        CMD_SCAN_START: begin
          last_scan_q <= now_q;
          ival_q      <= ival_d;
          idx_q       <= '0;
          wp_q        <= '0;
        end
        CMD_SCAN_EVAL: begin
          idx_q <= idx_q + 1'b1;
          if (drop) begin
            drops_q <= drops_q + 7'd1;
            nres_q  <= nres_q + 7'd1;
          end else begin
            wp_q <= wp_q + 1'b1;
            if (due) begin
              nres_q <= nres_q + 7'd1;
            end
          end
        end
        CMD_CHK_SIZE: begin
          if (list_full) begin
            count_q <= '0;
            nres_q  <= nres_q + 7'd1;
          end
        end
        CMD_RTT0: r_q <= 26'(rtt_q * RTT_SCALE);
        CMD_RTT1: begin
          num_q <= {interval_q, 2'b00} + 28'(r_q);
          gt_q  <= r_q > 26'(interval_q);
        end
        CMD_RTT2: quot_q <= prod5[56:31];
        CMD_RTT3: interval_q <= (v_sel > 26'(max_int_q)) ? max_int_q : v_sel[23:0];
        CMD_PUSH_DONE: begin
          if (nres_q == 7'd0) begin
            nres_q <= 7'd1;
          end
          oj_q <= '0;
        end
        CMD_OUT_NEXT: oj_q <= oj_q + 7'd1;
        default: ;
      endcase
    end
  end

  // status to the controller
  assign status_o = '{
    func:         func_q,
    idx_eq_count: (idx_q == count_q),
    cur_eq_end:   (cur_q == send_q),
    dup:          (ent_q.seq == cur_q),
    table_full:   (count_q == CW'(TABLE_DEPTH)),
    shift_done:   (idx_q == pos_q),
    match:        (ent_q.seq == sfirst_q),
    early:        early,
    res_full:     (nres_q == 7'(MAX_RESULTS)),
    young:        (!drop && young),
    last_res:     ((oj_q + 7'd1) == nres_q)
  };

  // output payload
  assign kind_o          = rb_q.kind;
  assign seq_out_o       = rb_q.seq;
  assign timeout_count_o = rb_q.tmo;
  assign entry_count_o   = 7'(count_q);
  assign overflow_o      = ovf_q;
  assign last_o          = status_o.last_res;

endmodule
